// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file b64d_checker.sv.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold a condition at every clock edge out of reset.
`define B64_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// Require the consequent in the cycle after the antecedent.
`define B64_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/b64d_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_pkg
// Types, codes and the character decoder shared by the Base64 decoder.
// ---------------------------------------------------------------------------
package b64d_pkg;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_SINGLE  = 2'd1;
    localparam logic [1:0] ERR_BADCHAR = 2'd2;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PAD     = 8'h3D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic       bad;
        logic       pad;
        logic [5:0] val;
    } t_sext;

    // One decoded group or error, released as 1 to 3 results
    typedef struct packed {
        logic [1:0]      count;
        logic [1:0]      err;
        logic [2:0][7:0] bytes;
    } t_job;

    function automatic t_sext decode_char(input logic [7:0] ch);
        t_sext s;
        s.bad = 1'b0;
        s.pad = 1'b0;
        s.val = '0;
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
            s.val = 6'(ch - CH_UPPER_A);
        end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
            s.val = 6'(ch - CH_LOWER_A + 8'd26);
        end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
            s.val = 6'(ch - CH_DIGIT_0 + 8'd52);
        end else if (ch == CH_PLUS) begin
            s.val = 6'd62;
        end else if (ch == CH_SLASH) begin
            s.val = 6'd63;
        end else if (ch == CH_PAD) begin
            s.pad = 1'b1;
        end else begin
            s.bad = 1'b1;
        end
        return s;
    endfunction

endpackage

// ----- design/b64d_if.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d stream interfaces
// Character input channel and byte result channel, valid/ready handshake.
// ---------------------------------------------------------------------------
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] char_code;

    modport source (output valid, output func, output char_code, input ready);
    modport sink   (input valid, input func, input char_code, output ready);
endinterface

interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;
    logic [1:0] error;

    modport source (output valid, output data_byte, output last, output error, input ready);
    modport sink   (input valid, input data_byte, input last, input error, output ready);
endinterface

// ----- design/b64d_front.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_front
// Accepts characters and flushes, tracks the group and queues decoded jobs.
// ---------------------------------------------------------------------------
module b64d_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    b64d_in_if.sink        i_in,
    output logic           o_push_valid,
    output b64d_pkg::t_job o_push_job,
    input  logic           i_push_ready
);

    logic [1:0] r_phase, n_phase;
    logic [5:0] r_a, r_b, r_c;
    logic       r_c_pad;
    logic       accept;
    logic       bad;
    logic       need_push;
    logic [5:0] c_use;
    b64d_pkg::t_sext sx;
    b64d_pkg::t_job  job;

    assign i_in.ready = i_push_ready;
    assign accept     = i_in.valid && i_push_ready;
    assign sx         = b64d_pkg::decode_char(i_in.char_code);

    // A padded third character decodes as zero, as does an absent one
    assign c_use = (r_phase == 2'd3) ? r_c : 6'd0;
    assign bad   = sx.bad || (sx.pad && r_phase < 2'd2)
                || (r_phase == 2'd3 && r_c_pad && !sx.pad);

    always_comb begin
        n_phase           = r_phase;
        need_push         = 1'b0;
        job.err           = b64d_pkg::ERR_NONE;
        job.count         = 2'd1;
        job.bytes[0]      = {r_a, r_b[5:4]};
        job.bytes[1]      = {r_b[3:0], c_use[5:2]};
        job.bytes[2]      = {c_use[1:0], sx.val};
        if (i_in.func) begin
            case (r_phase)
                2'd0: begin
                    need_push = 1'b0;
                end
                2'd1: begin
                    need_push = 1'b1;
                    job.err   = b64d_pkg::ERR_SINGLE;
                    job.bytes = '0;
                    n_phase   = 2'd0;
                end
                2'd2: begin
                    need_push = 1'b1;
                    n_phase   = 2'd0;
                end
                default: begin
                    need_push = 1'b1;
                    job.count = r_c_pad ? 2'd1 : 2'd2;
                    n_phase   = 2'd0;
                end
            endcase
        end else if (bad) begin
            // drop the character, keep the group
            need_push = 1'b1;
            job.err   = b64d_pkg::ERR_BADCHAR;
            job.bytes = '0;
        end else if (r_phase != 2'd3) begin
            n_phase = r_phase + 2'd1;
        end else begin
            need_push = 1'b1;
            job.count = sx.pad ? (r_c_pad ? 2'd1 : 2'd2) : 2'd3;
            n_phase   = 2'd0;
        end
    end

    assign o_push_valid = i_in.valid && need_push;
    assign o_push_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
        end else if (accept) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !i_in.func && !bad) begin
            case (r_phase)
                2'd0: r_a <= sx.val;
                2'd1: r_b <= sx.val;
                2'd2: begin
                    r_c     <= sx.val;
                    r_c_pad <= sx.pad;
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- design/b64d_queue.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_queue
// Short job queue that decouples the front from the result stage.
// ---------------------------------------------------------------------------
module b64d_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    input  b64d_pkg::t_job i_push_job,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output b64d_pkg::t_job o_pop_job,
    input  logic           i_pop_ready
);

    b64d_pkg::t_job r_mem [b64d_pkg::QUEUE_DEPTH];
    logic [b64d_pkg::QUEUE_AW-1:0] r_wptr, r_rptr;
    logic [b64d_pkg::QUEUE_AW:0]   r_count;
    logic push, pop;

    assign o_push_ready = (r_count != (b64d_pkg::QUEUE_AW+1)'(b64d_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_job    = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_job;
        end
    end

endmodule

// ----- design/b64d_back.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_back
// Result stage: takes one job at a time and sends its results one a cycle while the output is ready.
// ---------------------------------------------------------------------------
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    input  b64d_pkg::t_job i_pop_job,
    output logic           o_pop_ready,
    b64d_out_if.source     o_out
);

    logic           r_busy;
    b64d_pkg::t_job r_job;
    logic [1:0]     r_idx;
    logic           is_last, take, load;

    assign is_last = (r_idx == 2'(r_job.count - 2'd1));
    assign take    = r_busy && o_out.ready;
    assign load    = !r_busy || (take && is_last);

    assign o_pop_ready = load;
    assign o_out.valid = r_busy;
    assign o_out.last  = is_last;
    assign o_out.error = r_job.err;

    always_comb begin
        case (r_idx)
            2'd0:    o_out.data_byte = r_job.bytes[0];
            2'd1:    o_out.data_byte = r_job.bytes[1];
            default: o_out.data_byte = r_job.bytes[2];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (load) begin
            r_busy <= i_pop_valid;
            r_idx  <= 2'd0;
        end else if (take) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_pop_job;
        end
    end

endmodule

// ----- design/base64_stream_decoder_unit.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_unit
// Streaming Base64 (standard alphabet) decoder, one character per transaction.
// ---------------------------------------------------------------------------
// A character or flush transaction is taken every cycle while the four-entry
// job queue has room. Each fourth character of a group, a bad character or a
// flush mid-group queues one job; the result stage sends its 1 to 3 results
// one per cycle unless stalled, each job passing a queue entry and the result
// register. A full group gives three results per four characters, so the
// single result port keeps pace with one character per cycle; back-pressure
// on the result side fills the queue and then holds off input.
module base64_stream_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    b64d_in_if.sink    i_in,
    b64d_out_if.source o_out
);

    logic           push_valid, push_ready;
    logic           pop_valid, pop_ready;
    b64d_pkg::t_job push_job, pop_job;

    b64d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_job   (push_job),
        .i_push_ready (push_ready)
    );

    b64d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_job   (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_job    (pop_job),
        .i_pop_ready  (pop_ready)
    );

    b64d_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_job   (pop_job),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

// ----- design/b64d_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module b64d_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_data_byte,
    input logic       i_out_last,
    input logic [1:0] i_out_error
);

    `B64_ASSERT_NEXT(a_valid_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped while stalled")
    `B64_ASSERT_NEXT(a_payload_hold, i_out_valid && !i_out_ready, $stable(i_out_data_byte) && $stable(i_out_last) && $stable(i_out_error), "result changed while stalled")
    `B64_ASSERT_ALWAYS(a_err_single, !i_out_valid || i_out_error == b64d_pkg::ERR_NONE || (i_out_last && i_out_data_byte == 8'd0), "error result not a lone zero result")
    `B64_ASSERT_ALWAYS(a_err_code, !i_out_valid || i_out_error == b64d_pkg::ERR_NONE || i_out_error == b64d_pkg::ERR_SINGLE || i_out_error == b64d_pkg::ERR_BADCHAR, "unknown error code")

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_data_byte (o_out.data_byte),
    .i_out_last      (o_out.last),
    .i_out_error     (o_out.error)
);

// ----- dv/b64d_tb_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// b64d_tb_pkg
// Transaction codes and the result record shared by the decoder testbench.
// ---------------------------------------------------------------------------
package b64d_tb_pkg;

    localparam logic FUNC_CHAR  = 1'b0;
    localparam logic FUNC_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic [1:0] error;
    } t_byte_result;

endpackage

// ----- dv/base64_decode_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_decode_checker
// Watches both channels of the decoder, predicts the decoded bytes and error
// results of every accepted transaction and compares them in order.
// ---------------------------------------------------------------------------
module base64_decode_checker
    import b64d_pkg::*;
    import b64d_tb_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    b64d_in_if    i_in_ch,
    b64d_out_if   i_out_ch,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked
);

    localparam int SEXT_PAD = 64;
    localparam int SEXT_BAD = 65;
    localparam int MAX_REPORTS = 20;

    logic [1:0]   held_count;
    logic [7:0]   held_chars [3];
    t_byte_result expected_bytes [$];
    int           fail_count;
    int           checked;

    // 0..63 for alphabet characters, SEXT_PAD for padding, SEXT_BAD otherwise
    function automatic int sextet_of(input logic [7:0] ch);
        if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) return int'(ch - CH_UPPER_A);
        if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) return int'(ch - CH_LOWER_A) + 26;
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) return int'(ch - CH_DIGIT_0) + 52;
        if (ch == CH_PLUS) return 62;
        if (ch == CH_SLASH) return 63;
        if (ch == CH_PAD) return SEXT_PAD;
        return SEXT_BAD;
    endfunction

    function automatic logic [5:0] six_bits(input logic [7:0] ch);
        int v;
        v = sextet_of(ch);
        return (v < 64) ? 6'(v) : 6'd0;
    endfunction

    // Append one predicted result at the tail of the queue
    task automatic queue_expected(input t_byte_result r);
        expected_bytes.insert(expected_bytes.size(), r);
    endtask

    task automatic release_bytes(input int n, input logic [7:0] c2, input logic [7:0] c3);
        logic [5:0] a, b, c, d;
        logic [7:0] group [3];
        int k;
        a = six_bits(held_chars[0]);
        b = six_bits(held_chars[1]);
        c = six_bits(c2);
        d = six_bits(c3);
        group[0] = {a, b[5:4]};
        group[1] = {b[3:0], c[5:2]};
        group[2] = {c[1:0], d};
        for (k = 0; k < n; k++) begin
            queue_expected('{group[k], (k == n - 1), ERR_NONE});
        end
        held_count = 2'd0;
        held_chars = '{default: 8'd0};
    endtask

    task automatic decode_transaction(input logic f, input logic [7:0] ch);
        int  v;
        logic bad;
        if (f == FUNC_FLUSH) begin
            case (held_count)
                2'd0: ;
                2'd1: begin
                    queue_expected('{8'd0, 1'b1, ERR_SINGLE});
                    held_count = 2'd0;
                    held_chars = '{default: 8'd0};
                end
                2'd2: release_bytes(1, CH_UPPER_A, CH_UPPER_A);
                default: begin
                    if (held_chars[2] == CH_PAD) begin
                        release_bytes(1, CH_UPPER_A, CH_UPPER_A);
                    end else begin
                        release_bytes(2, held_chars[2], CH_UPPER_A);
                    end
                end
            endcase
            return;
        end
        v = sextet_of(ch);
        bad = (v == SEXT_BAD) || (v == SEXT_PAD && held_count < 2'd2) ||
              (held_count == 2'd3 && held_chars[2] == CH_PAD && v != SEXT_PAD);
        // Drop the character and leave the group as it was
        if (bad) begin
            queue_expected('{8'd0, 1'b1, ERR_BADCHAR});
            return;
        end
        if (held_count < 2'd3) begin
            held_chars[held_count] = ch;
            held_count = held_count + 2'd1;
        end else if (v == SEXT_PAD) begin
            if (held_chars[2] == CH_PAD) begin
                release_bytes(1, CH_UPPER_A, CH_UPPER_A);
            end else begin
                release_bytes(2, held_chars[2], CH_UPPER_A);
            end
        end else begin
            release_bytes(3, held_chars[2], ch);
        end
    endtask

    task automatic check_result(input t_byte_result got);
        t_byte_result want;
        checked++;
        if (expected_bytes.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: unexpected result, expected none, got byte %02h last %0b error %0d",
                         $time, got.data_byte, got.last, got.error);
            end
            return;
        end
        want = expected_bytes.pop_front();
        if (got.data_byte !== want.data_byte || got.last !== want.last ||
            got.error !== want.error) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
                $display("%0t: result mismatch, expected byte %02h last %0b error %0d,",
                         $time, want.data_byte, want.last, want.error);
                $display("    got byte %02h last %0b error %0d",
                         got.data_byte, got.last, got.error);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 2'd0;
            held_chars = '{default: 8'd0};
            expected_bytes.delete();
            fail_count = 0;
            checked = 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                decode_transaction(i_in_ch.func, i_in_ch.char_code);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                check_result('{i_out_ch.data_byte, i_out_ch.last, i_out_ch.error});
            end
        end
        o_fail_count <= fail_count;
        o_pending <= expected_bytes.size();
        o_checked <= checked;
    end

endmodule

// ----- dv/base64_stream_decoder_unit_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// base64_stream_decoder_unit_tb
// Drives directed and random Base64 character streams with flushes, padding
// and bad codes through the decoder under several idle and stall mixes, and
// a long result hold-off; the checker beside the block scores every result.
// ---------------------------------------------------------------------------
module base64_stream_decoder_unit_tb;
    import b64d_pkg::*;
    import b64d_tb_pkg::*;

    localparam int  HOLD_OFF_CYCLES = 80;
    localparam int  DRAIN_CYCLES    = 20;
    localparam int  RANDOM_ITEMS    = 88;
    localparam time TIMEOUT_NS      = 4_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    b64d_in_if  in_ch ();
    b64d_out_if out_ch ();

    int   send_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_off = 1'b0;
    int   items_sent = 0;
    int   flushes_sent = 0;
    int   noise_sent = 0;
    int   fail_count;
    int   pending;
    int   checked;

    base64_stream_decoder_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    base64_decode_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("base64_stream_decoder_unit regression: fail");
        $finish;
    end

    // Result side: random stalls, or a solid hold-off when asked
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [7:0] alpha_char(input int v);
        if (v < 26) return CH_UPPER_A + 8'(v);
        if (v < 52) return CH_LOWER_A + 8'(v - 26);
        if (v < 62) return CH_DIGIT_0 + 8'(v - 52);
        return (v == 62) ? CH_PLUS : CH_SLASH;
    endfunction

    function automatic logic [7:0] any_alpha();
        return alpha_char($urandom_range(63));
    endfunction

    task automatic push_item(input logic f, input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
            in_ch.func <= 1'($urandom_range(1));
            in_ch.char_code <= 8'($urandom_range(255));
        end
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.func <= f;
        in_ch.char_code <= ch;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
        if (f == FUNC_FLUSH) flushes_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) push_item(FUNC_CHAR, s[i]);
    endtask

    task automatic push_flush();
        push_item(FUNC_FLUSH, 8'($urandom_range(255)));
    endtask

    task automatic push_group();
        int k;
        for (k = 0; k < 4; k++) push_item(FUNC_CHAR, any_alpha());
    endtask

    // Mostly well-formed groups, with padded and flushed endings, broken
    // padding and raw noise mixed in
    task automatic push_random_sequence();
        int kind;
        int k;
        kind = $urandom_range(99);
        if (kind < 50) begin
            push_group();
        end else if (kind < 60) begin
            push_item(FUNC_CHAR, any_alpha());
            push_item(FUNC_CHAR, any_alpha());
            push_item(FUNC_CHAR, CH_PAD);
            push_item(FUNC_CHAR, CH_PAD);
        end else if (kind < 68) begin
            for (k = 0; k < 3; k++) push_item(FUNC_CHAR, any_alpha());
            push_item(FUNC_CHAR, CH_PAD);
        end else if (kind < 76) begin
            k = $urandom_range(2, 3);
            while (k > 0) begin
                push_item(FUNC_CHAR, any_alpha());
                k--;
            end
            push_flush();
        end else if (kind < 80) begin
            push_item(FUNC_CHAR, any_alpha());
            push_flush();
        end else if (kind < 85) begin
            // Character after padding, then pad or flush to close the group
            push_item(FUNC_CHAR, any_alpha());
            push_item(FUNC_CHAR, any_alpha());
            push_item(FUNC_CHAR, CH_PAD);
            push_item(FUNC_CHAR, ($urandom_range(1) != 0) ? any_alpha() : 8'($urandom_range(255)));
            if ($urandom_range(1) != 0) push_item(FUNC_CHAR, CH_PAD);
            else push_flush();
        end else if (kind < 95) begin
            push_item(FUNC_CHAR, 8'($urandom_range(255)));
            noise_sent++;
        end else begin
            push_flush();
        end
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall);
        int target;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        target = items_sent + n;
        while (items_sent < target) push_random_sequence();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_CHAR;
        in_ch.char_code = 8'd0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, padding forms, bad codes and every flush depth
        push_text("AAAA");
        push_text("/+9=");
        push_item(FUNC_CHAR, CH_PAD);
        push_item(FUNC_CHAR, 8'hFF);
        push_flush();
        push_text("z");
        push_flush();
        push_text("Qk");
        push_flush();
        push_text("Zm=x");
        push_flush();
        push_text("QUJ");
        push_flush();

        run_random(RANDOM_ITEMS, 0, 0);
        run_random(RANDOM_ITEMS, 59, 0);
        run_random(RANDOM_ITEMS, 0, 59);
        run_random(RANDOM_ITEMS, 37, 37);

        // Hold the result side off long enough to fill the job queue
        send_idle_pct = 0;
        stall_pct = 0;
        hold_off = 1'b1;
        fork
            begin
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end
            repeat (10) push_group();
        join

        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d transactions (%0d flushes, %0d raw noise codes) over four idle mixes",
                 items_sent, flushes_sent, noise_sent);
        $display("and a long result hold-off; %0d results compared.", checked);
        if (fail_count == 0) begin
            $display("base64_stream_decoder_unit regression: pass");
        end else begin
            $display("base64_stream_decoder_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/b64d_pkg.sv
design/b64d_if.sv
design/b64d_front.sv
design/b64d_queue.sv
design/b64d_back.sv
design/base64_stream_decoder_unit.sv
design/b64d_checker.sv
dv/b64d_tb_pkg.sv
dv/base64_decode_checker.sv
dv/base64_stream_decoder_unit_tb.sv
